[hw/rtl/lidar_serial_frame_parser_core_defines.svh]
// assertion macros shared by the lidar frame parser rtl
// expects a clock named clk and an active high reset named rst in scope
`ifndef LIDAR_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH
`define LIDAR_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LSFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LSFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lsfp_pkg.sv]
// shared types and constants of the lidar serial frame parser
// no dependencies
`timescale 1ns / 1ps

package lsfp_pkg;

  // register map
  localparam int unsigned     AddrW          = 3;
  localparam logic [0:0]      RegHeaderIdx   = 1'b0;
  localparam logic [7:0]      HeaderReset    = 8'h59;

  // position within the nine byte frame, one-hot
  typedef enum logic [8:0] {
    POS_HUNT   = 9'b0_0000_0001,
    POS_HDR2   = 9'b0_0000_0010,
    POS_DIST_L = 9'b0_0000_0100,
    POS_DIST_H = 9'b0_0000_1000,
    POS_STR_L  = 9'b0_0001_0000,
    POS_STR_H  = 9'b0_0010_0000,
    POS_RSVD   = 9'b0_0100_0000,
    POS_QUAL   = 9'b0_1000_0000,
    POS_CSUM   = 9'b1_0000_0000
  } pos_t;

  // one decoded frame
  typedef struct packed {
    logic [15:0] distance_cm;
    logic [15:0] strength;
    logic [7:0]  quality;
    logic        checksum_ok;
  } frame_t;

  // request from the parser into the output register
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

endpackage

[hw/rtl/lidar_serial_frame_parser_core.sv]
// Lidar serial frame parser, top level.
// Input channel in_valid/in_ready/rx_byte takes one received serial byte per request.
// The block hunts for two header bytes equal to the header register, then
// collects distance, strength, reserved, quality and checksum bytes.
// On the ninth byte one result request goes out on out_valid/out_ready with
// distance_cm, strength, quality and checksum_ok (low byte of the sum of the
// first eight bytes against the ninth). A bad checksum still gives a result.
// Throughput: one byte per cycle, set by the single input register stage, unless
// a checksum byte waits for the output register. Each byte is processed from the
// input register; the result is registered when the checksum byte is processed.
// When the receiver stalls, non-final bytes keep flowing; a checksum byte
// waits in the input register until the output register frees.
// Reset (rst, synchronous) restores header 0x59, empties both registers and
// returns to hunting the first header. Config: APB, header at address 0.
// depends on lsfp_pkg, lsfp_cfg_regs, lsfp_parser, lsfp_out_reg
`timescale 1ns / 1ps

module lidar_serial_frame_parser_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsfp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                distance_cm,
  output logic [15:0]                strength,
  output logic [7:0]                 quality,
  output logic                       checksum_ok
);

  logic                 [7:0] header_byte;
  logic                       out_free;
  lsfp_pkg::frame_req_t       frame_req;
  lsfp_pkg::frame_t           frame;

  // configuration registers
  lsfp_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .header_byte (header_byte)
  );

  // byte register and frame state
  lsfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .header_byte (header_byte),
    .out_free    (out_free),
    .frame_req   (frame_req)
  );

  // result register
  lsfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .frame_req (frame_req),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame     (frame)
  );

  assign distance_cm = frame.distance_cm;
  assign strength    = frame.strength;
  assign quality     = frame.quality;
  assign checksum_ok = frame.checksum_ok;

endmodule

[hw/rtl/lsfp_cfg_regs.sv]
// apb register block holding the frame header byte
// depends on lsfp_pkg
`timescale 1ns / 1ps

module lsfp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsfp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [7:0]                 header_byte
);

  logic hit;
  logic wr_en;

  // decode the word index, low address bits ignored
  assign hit    = (paddr[2:2] == lsfp_pkg::RegHeaderIdx);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  // header register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= lsfp_pkg::HeaderReset;
    end else if (wr_en) begin
      header_byte <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'h0;
    if (hit) begin
      prdata = {24'h0, header_byte};
    end
  end

endmodule

[hw/rtl/lsfp_parser.sv]
// input byte register and frame state machine of the lidar frame parser
// depends on lsfp_pkg and lidar_serial_frame_parser_core_defines.svh
`timescale 1ns / 1ps
`include "lidar_serial_frame_parser_core_defines.svh"

module lsfp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           header_byte,
  input  logic                 out_free,
  output lsfp_pkg::frame_req_t frame_req
);

  logic           in_full;
  logic           in_full_next;
  logic [7:0]     byte_q;
  lsfp_pkg::pos_t pos;
  lsfp_pkg::pos_t pos_next;
  logic [7:0]     running_sum;
  logic [7:0]     running_sum_next;
  logic [7:0]     dist_lo;
  logic [7:0]     dist_hi;
  logic [7:0]     str_lo;
  logic [7:0]     str_hi;
  logic [7:0]     qual;
  logic [7:0]     sum_add;
  logic           is_last;
  logic           proceed;
  logic           accept;

  // a byte moves on unless it completes a frame and the output is full
  assign is_last  = (pos == lsfp_pkg::POS_CSUM);
  assign proceed  = in_full && (!is_last || out_free);
  assign in_ready = !in_full || proceed;
  assign accept   = in_valid && in_ready;
  assign sum_add  = running_sum + byte_q;

  assign in_full_next = accept || (in_full && !proceed);

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= rx_byte;
    end
  end

  // next position and checksum
  always_comb begin
    pos_next         = pos;
    running_sum_next = sum_add;
    unique case (pos)
      lsfp_pkg::POS_HUNT: begin
        running_sum_next = byte_q;
        if (byte_q == header_byte) begin
          pos_next = lsfp_pkg::POS_HDR2;
        end
      end
      lsfp_pkg::POS_HDR2: begin
        if (byte_q == header_byte) begin
          pos_next = lsfp_pkg::POS_DIST_L;
        end else begin
          pos_next = lsfp_pkg::POS_HUNT;
        end
      end
      lsfp_pkg::POS_DIST_L: pos_next = lsfp_pkg::POS_DIST_H;
      lsfp_pkg::POS_DIST_H: pos_next = lsfp_pkg::POS_STR_L;
      lsfp_pkg::POS_STR_L:  pos_next = lsfp_pkg::POS_STR_H;
      lsfp_pkg::POS_STR_H:  pos_next = lsfp_pkg::POS_RSVD;
      lsfp_pkg::POS_RSVD:   pos_next = lsfp_pkg::POS_QUAL;
      lsfp_pkg::POS_QUAL:   pos_next = lsfp_pkg::POS_CSUM;
      lsfp_pkg::POS_CSUM:   pos_next = lsfp_pkg::POS_HUNT;
      default:              pos_next = lsfp_pkg::POS_HUNT;
    endcase
  end

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= lsfp_pkg::POS_HUNT;
    end else if (proceed) begin
      pos <= pos_next;
    end
  end

  // running sum, only updated where the hunt does not drop the byte
  always_ff @(posedge clk) begin
    if (proceed && ((pos != lsfp_pkg::POS_HUNT) || (byte_q == header_byte))) begin
      running_sum <= running_sum_next;
    end
  end

  // captured payload bytes
  always_ff @(posedge clk) begin
    if (proceed) begin
      if (pos == lsfp_pkg::POS_DIST_L) begin
        dist_lo <= byte_q;
      end
      if (pos == lsfp_pkg::POS_DIST_H) begin
        dist_hi <= byte_q;
      end
      if (pos == lsfp_pkg::POS_STR_L) begin
        str_lo <= byte_q;
      end
      if (pos == lsfp_pkg::POS_STR_H) begin
        str_hi <= byte_q;
      end
      if (pos == lsfp_pkg::POS_QUAL) begin
        qual <= byte_q;
      end
    end
  end

  // completed frame request
  assign frame_req.valid             = proceed && is_last;
  assign frame_req.frame.distance_cm = {dist_hi, dist_lo};
  assign frame_req.frame.strength    = {str_hi, str_lo};
  assign frame_req.frame.quality     = qual;
  assign frame_req.frame.checksum_ok = (running_sum == byte_q);

  `LSFP_ASSERT_SAME(a_req_into_free, frame_req.valid, out_free,
                    "frame request while output register is full")
  `LSFP_ASSERT_SAME(a_empty_ready, !in_full, in_ready,
                    "input stage empty but not ready")
  `LSFP_ASSERT_NEXT(a_csum_to_hunt, proceed && is_last, pos == lsfp_pkg::POS_HUNT,
                    "checksum byte did not return to hunt")
  `LSFP_ASSERT_NEXT(a_hdr2_miss,
                    proceed && (pos == lsfp_pkg::POS_HDR2) && (byte_q != header_byte),
                    pos == lsfp_pkg::POS_HUNT,
                    "second header mismatch did not restart hunt")

endmodule

[hw/rtl/lsfp_out_reg.sv]
// output register of the lidar frame parser
// depends on lsfp_pkg
`timescale 1ns / 1ps

module lsfp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  lsfp_pkg::frame_req_t frame_req,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsfp_pkg::frame_t     frame
);

  logic out_valid_next;

  // free when empty or emptying this cycle
  assign out_free       = !out_valid || out_ready;
  assign out_valid_next = frame_req.valid || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (frame_req.valid) begin
      frame <= frame_req.frame;
    end
  end

endmodule
